// ===== hw/rtl/touch_swipe_gesture_recognizer_assert.svh =====
// assertion macros used by the gesture recognizer checker
`ifndef TOUCH_SWIPE_GESTURE_RECOGNIZER_ASSERT_SVH
`define TOUCH_SWIPE_GESTURE_RECOGNIZER_ASSERT_SVH

// same-cycle implication, dis disables the check
`define TSGR_ASSERT_IMPLY(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, dis disables the check
`define TSGR_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tsgr_pkg.sv =====
// shared types and constants of the touch swipe gesture recognizer
`default_nettype none

package tsgr_pkg;

  localparam int          IGNORE_DEPTH_DEF = 2;
  localparam logic [15:0] MIN_MOVE_RESET   = 16'd10;
  localparam int          QUEUE_DEPTH      = 2;
  localparam int          COORD_W          = 15;

  // touch event codes
  localparam logic [1:0] OP_POINT = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_LIFT  = 2'd2;

  typedef enum logic [1:0] {
    CMD_MOVE,
    CMD_CLEAR,
    CMD_LIFT
  } cmd_kind_t;

  typedef enum logic [2:0] {
    DIR_RIGHT,
    DIR_UP_RIGHT,
    DIR_UP,
    DIR_UP_LEFT,
    DIR_LEFT,
    DIR_DOWN_LEFT,
    DIR_DOWN,
    DIR_DOWN_RIGHT
  } dir_t;

  // swipe automaton: start, no gesture, then one state per straight direction
  typedef enum logic [3:0] {
    SW_START,
    SW_NONE,
    SW_RIGHT,
    SW_UP_RIGHT,
    SW_UP,
    SW_UP_LEFT,
    SW_LEFT,
    SW_DOWN_LEFT,
    SW_DOWN,
    SW_DOWN_RIGHT
  } sw_state_t;

  typedef struct packed {
    cmd_kind_t          kind;
    dir_t               dir;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tsgr_queue.sv =====
// short command queue between the classifying front and the automaton back
`default_nettype none

module tsgr_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push_valid,
  input  tsgr_pkg::cmd_t   push_cmd,
  output logic             push_ready,
  output logic             pop_valid,
  output tsgr_pkg::cmd_t   pop_cmd,
  input  wire              pop_ready
);

  localparam int QD = tsgr_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  tsgr_pkg::cmd_t mem [QD];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != CW'(QD));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(QD - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(QD - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tsgr_front.sv =====
// front end: tracks the last point, applies the distance threshold, sorts moves
`default_nettype none

module tsgr_front (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [1:0]                    op,
  input  wire  [tsgr_pkg::COORD_W-1:0]  pos_x,
  input  wire  [tsgr_pkg::COORD_W-1:0]  pos_y,
  input  wire  [15:0]                   min_move_distance,
  output logic                          push_valid,
  output tsgr_pkg::cmd_t                push_cmd,
  input  wire                           push_ready
);

  localparam int CW = tsgr_pkg::COORD_W;

  logic          have_last;
  logic [CW-1:0] last_x;
  logic [CW-1:0] last_y;
  logic [CW-1:0] start_x;
  logic [CW-1:0] start_y;

  logic          accept;
  logic [CW:0]   dx;
  logic [CW:0]   dy;
  logic [CW-1:0] adx;
  logic [CW-1:0] ady;
  logic [CW:0]   move_len;
  logic          far;
  logic          pos_dx;
  logic          pos_dy;
  logic          diag;
  tsgr_pkg::dir_t dir;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  always_comb begin
    dx       = {1'b0, pos_x} - {1'b0, last_x};
    dy       = {1'b0, pos_y} - {1'b0, last_y};
    adx      = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady      = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    move_len = {1'b0, adx} + {1'b0, ady};
    far      = (move_len >= min_move_distance);
    pos_dx   = !dx[CW] && (dx != '0);
    pos_dy   = !dy[CW] && (dy != '0);
    // diagonal when the axis difference is at most half the larger axis
    if (adx > ady) begin
      diag = (adx - ady) <= (adx >> 1);
    end else begin
      diag = (ady - adx) <= (ady >> 1);
    end
    if (diag) begin
      if (pos_dx) begin
        dir = pos_dy ? tsgr_pkg::DIR_DOWN_RIGHT : tsgr_pkg::DIR_UP_RIGHT;
      end else begin
        dir = pos_dy ? tsgr_pkg::DIR_DOWN_LEFT : tsgr_pkg::DIR_UP_LEFT;
      end
    end else if (adx > ady) begin
      dir = pos_dx ? tsgr_pkg::DIR_RIGHT : tsgr_pkg::DIR_LEFT;
    end else begin
      dir = pos_dy ? tsgr_pkg::DIR_DOWN : tsgr_pkg::DIR_UP;
    end
  end

  always_comb begin
    push_valid       = 1'b0;
    push_cmd.kind    = tsgr_pkg::CMD_MOVE;
    push_cmd.dir     = dir;
    push_cmd.start_x = start_x;
    push_cmd.start_y = start_y;
    unique case (op)
      tsgr_pkg::OP_START: begin
        push_valid    = accept;
        push_cmd.kind = tsgr_pkg::CMD_CLEAR;
      end
      tsgr_pkg::OP_LIFT: begin
        push_valid    = accept;
        push_cmd.kind = tsgr_pkg::CMD_LIFT;
      end
      tsgr_pkg::OP_POINT: begin
        push_valid = accept && have_last && far;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
    end else if (accept) begin
      if (op == tsgr_pkg::OP_START) begin
        have_last <= 1'b0;
      end else if (op == tsgr_pkg::OP_POINT) begin
        have_last <= 1'b1;
      end
    end
  end

  // short moves keep the old reference point
  always_ff @(posedge clk) begin
    if (accept && (op == tsgr_pkg::OP_POINT) && (!have_last || far)) begin
      last_x <= pos_x;
      last_y <= pos_y;
    end
    if (accept && (op == tsgr_pkg::OP_POINT) && !have_last) begin
      start_x <= pos_x;
      start_y <= pos_y;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tsgr_back.sv =====
// back end: swipe automaton behind the delay line, lift reporting, result register
`default_nettype none

module tsgr_back #(
  parameter int IGNORE_DEPTH = tsgr_pkg::IGNORE_DEPTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           pop_valid,
  input  tsgr_pkg::cmd_t                pop_cmd,
  output logic                          pop_ready,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [2:0]                    gesture_dir,
  output logic [tsgr_pkg::COORD_W-1:0]  origin_x,
  output logic [tsgr_pkg::COORD_W-1:0]  origin_y
);

  localparam int             MCW     = $clog2(2 * IGNORE_DEPTH + 1);
  localparam logic [MCW-1:0] FILL_AT = MCW'(IGNORE_DEPTH);
  localparam logic [MCW-1:0] RUN_AT  = MCW'(2 * IGNORE_DEPTH);

  tsgr_pkg::sw_state_t cur;
  tsgr_pkg::sw_state_t cur_next;
  logic [MCW-1:0]      mcount;
  logic [MCW-1:0]      mcount_next;
  tsgr_pkg::sw_state_t ring [IGNORE_DEPTH];
  tsgr_pkg::sw_state_t ring_in;
  logic                ring_shift;
  logic                take;
  logic                emit;
  logic                lift;
  logic                load_out;
  logic [2:0]          dir_code;

  function automatic tsgr_pkg::sw_state_t advance(input tsgr_pkg::sw_state_t s,
                                                  input tsgr_pkg::dir_t d);
    logic [3:0]          tgt;
    tsgr_pkg::sw_state_t nxt;
    tgt = 4'(tsgr_pkg::SW_RIGHT) + {1'b0, d};
    unique case (s)
      tsgr_pkg::SW_START: nxt = tsgr_pkg::sw_state_t'(tgt);
      tsgr_pkg::SW_NONE:  nxt = tsgr_pkg::SW_NONE;
      default:            nxt = (4'(s) == tgt) ? s : tsgr_pkg::SW_NONE;
    endcase
    return nxt;
  endfunction

  assign take = pop_valid && pop_ready;

  // next state of the automaton and the delay line
  always_comb begin
    cur_next    = cur;
    mcount_next = mcount;
    ring_shift  = 1'b0;
    // first entry of the fill phase starts from a fresh automaton
    ring_in     = advance((mcount == FILL_AT) ? tsgr_pkg::SW_START : ring[0], pop_cmd.dir);
    if (take) begin
      unique case (pop_cmd.kind)
        tsgr_pkg::CMD_CLEAR: begin
          cur_next    = tsgr_pkg::SW_START;
          mcount_next = '0;
        end
        tsgr_pkg::CMD_MOVE: begin
          if (mcount >= RUN_AT) begin
            cur_next   = ring[IGNORE_DEPTH-1];
            ring_shift = 1'b1;
          end else if (mcount >= FILL_AT) begin
            ring_shift  = 1'b1;
            mcount_next = mcount + 1'b1;
          end else begin
            mcount_next = mcount + 1'b1;
          end
        end
        default: begin
          cur_next = cur;
        end
      endcase
    end
  end

  // lift handling and result register control
  always_comb begin
    emit      = (cur != tsgr_pkg::SW_START) && (cur != tsgr_pkg::SW_NONE);
    lift      = (pop_cmd.kind == tsgr_pkg::CMD_LIFT);
    pop_ready = !(lift && emit) || !out_valid || out_ready;
    load_out  = take && lift && emit;
    dir_code  = 3'(4'(cur) - 4'(tsgr_pkg::SW_RIGHT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= tsgr_pkg::SW_START;
      mcount    <= '0;
      out_valid <= 1'b0;
    end else begin
      cur    <= cur_next;
      mcount <= mcount_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      gesture_dir <= dir_code;
      origin_x    <= pop_cmd.start_x;
      origin_y    <= pop_cmd.start_y;
    end
  end

  // newest entry at tap 0, oldest at the last tap
  always_ff @(posedge clk) begin
    if (ring_shift) begin
      ring[0] <= ring_in;
      for (int i = 1; i < IGNORE_DEPTH; i++) begin
        ring[i] <= ring[i-1];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/touch_swipe_gesture_recognizer.sv =====
// top level of the touch swipe gesture recognizer
`default_nettype none

// Touch swipe gesture recognizer. Takes one touch word (point, stroke start or
// lift) per clock while ready; the front end compares each point with the
// reference point in the same cycle and queues moves, stroke starts and lifts
// into a two-entry command queue, and the back end steps the swipe automaton
// one command per cycle unless a lift waits on a stalled result. A swipe and
// its stroke's first point reach the result port via the queue and the result
// register. Input ready drops only when a reported swipe sits untaken in the
// result register and the queue fills behind it. min_move_distance is written
// through the cfg port, which is always ready; it resets to 10.

module touch_swipe_gesture_recognizer #(
  parameter int IGNORE_DEPTH = tsgr_pkg::IGNORE_DEPTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [1:0]                    op,
  input  wire  [tsgr_pkg::COORD_W-1:0]  pos_x,
  input  wire  [tsgr_pkg::COORD_W-1:0]  pos_y,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [2:0]                    gesture_dir,
  output logic [tsgr_pkg::COORD_W-1:0]  origin_x,
  output logic [tsgr_pkg::COORD_W-1:0]  origin_y,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [15:0]                   cfg_data
);

  logic [15:0]    min_move_distance;
  logic           push_valid;
  logic           push_ready;
  tsgr_pkg::cmd_t push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  tsgr_pkg::cmd_t pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_move_distance <= tsgr_pkg::MIN_MOVE_RESET;
    end else if (cfg_valid) begin
      min_move_distance <= cfg_data;
    end
  end

  tsgr_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .op                (op),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .min_move_distance (min_move_distance),
    .push_valid        (push_valid),
    .push_cmd          (push_cmd),
    .push_ready        (push_ready)
  );

  tsgr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  tsgr_back #(
    .IGNORE_DEPTH (IGNORE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_cmd     (pop_cmd),
    .pop_ready   (pop_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .gesture_dir (gesture_dir),
    .origin_x    (origin_x),
    .origin_y    (origin_y)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tsgr_chk.sv =====
// port-level checks of the gesture recognizer, bound to the top level
`default_nettype none

`include "touch_swipe_gesture_recognizer_assert.svh"

module tsgr_chk (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [2:0]                    gesture_dir,
  input wire [tsgr_pkg::COORD_W-1:0]  origin_x,
  input wire [tsgr_pkg::COORD_W-1:0]  origin_y
);

  // a stalled result word holds still
  `TSGR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(gesture_dir) && $stable(origin_x) && $stable(origin_y), "result word changed while stalled")

  // reset leaves no result pending
  `TSGR_ASSERT_NEXT(a_rst_clear, clk, 1'b0, rst, !out_valid, "result pending after reset")

  // the queue only fills up behind a stalled result
  `TSGR_ASSERT_IMPLY(a_stall_cause, clk, rst, !in_ready, $past(out_valid && !out_ready), "input stalled without output backpressure")

endmodule

bind touch_swipe_gesture_recognizer tsgr_chk u_tsgr_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .gesture_dir (gesture_dir),
  .origin_x    (origin_x),
  .origin_y    (origin_y)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench of the touch swipe gesture recognizer: directed table, random strokes
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         COORD_W     = tsgr_pkg::COORD_W;
  localparam int         DEPTH       = tsgr_pkg::IGNORE_DEPTH_DEF;
  localparam int         COORD_MAX   = (1 << COORD_W) - 1;
  localparam int         CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]         dir;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
  } swipe_t;

  // how a directed row is checked: by the predictor, not at all, or by a typed result
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_HIT
  } chk_t;

  typedef struct {
    logic [1:0]         op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    chk_t               chk;
    swipe_t             res;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           op;
  logic [COORD_W-1:0]   pos_x;
  logic [COORD_W-1:0]   pos_y;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           gesture_dir;
  logic [COORD_W-1:0]   origin_x;
  logic [COORD_W-1:0]   origin_y;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [15:0]          cfg_data;

  // predictor state
  logic [15:0]          move_thresh;
  bit                   pt_valid;
  logic [COORD_W-1:0]   prev_x, prev_y, org_x, org_y;
  tsgr_pkg::sw_state_t  sw_cur;
  int                   moves_seen;
  int                   ring_rd, ring_wr;
  tsgr_pkg::sw_state_t  sw_ring [DEPTH];

  swipe_t               swipe_expect_q [$];
  stim_row_t            directed_rows [$];
  int                   mismatches;
  int                   sent_items;
  int                   cycles;
  bit                   quiet;

  touch_swipe_gesture_recognizer u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .gesture_dir (gesture_dir),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic tsgr_pkg::sw_state_t swipe_next(tsgr_pkg::sw_state_t s,
                                                      tsgr_pkg::dir_t d);
    tsgr_pkg::sw_state_t straight;
    straight = tsgr_pkg::sw_state_t'({1'b0, d} + 4'(tsgr_pkg::SW_RIGHT));
    if (s == tsgr_pkg::SW_START) return straight;
    if (s == straight) return s;
    return tsgr_pkg::SW_NONE;
  endfunction

  // diagonal when the gap between |dx| and |dy| is at most half the larger
  function automatic tsgr_pkg::dir_t heading(int dx, int dy);
    int adx, ady;
    bit diag;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    if (adx > ady) diag = (adx - ady) <= adx / 2;
    else diag = (ady - adx) <= ady / 2;
    if (diag) begin
      if (dx > 0) return dy > 0 ? tsgr_pkg::DIR_DOWN_RIGHT : tsgr_pkg::DIR_UP_RIGHT;
      return dy > 0 ? tsgr_pkg::DIR_DOWN_LEFT : tsgr_pkg::DIR_UP_LEFT;
    end
    if (adx > ady) return dx > 0 ? tsgr_pkg::DIR_RIGHT : tsgr_pkg::DIR_LEFT;
    return dy > 0 ? tsgr_pkg::DIR_DOWN : tsgr_pkg::DIR_UP;
  endfunction

  function automatic bit swipe_predict(input logic [1:0] o, input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y, output swipe_t res);
    int dx, dy, h, t;
    tsgr_pkg::dir_t d;
    tsgr_pkg::sw_state_t prior;
    res = '0;
    case (o)
      tsgr_pkg::OP_START: begin
        sw_cur = tsgr_pkg::SW_START;
        pt_valid = 1'b0;
        moves_seen = 0;
        ring_rd = 0;
        ring_wr = 0;
        sw_ring[0] = tsgr_pkg::SW_START;
      end
      tsgr_pkg::OP_LIFT: begin
        if (sw_cur >= tsgr_pkg::SW_RIGHT && sw_cur <= tsgr_pkg::SW_DOWN_RIGHT) begin
          res.dir = 3'(sw_cur - tsgr_pkg::SW_RIGHT);
          res.ox = org_x;
          res.oy = org_y;
          return 1'b1;
        end
      end
      tsgr_pkg::OP_POINT: begin
        if (!pt_valid) begin
          pt_valid = 1'b1;
          prev_x = x;
          prev_y = y;
          org_x = x;
          org_y = y;
        end else begin
          dx = int'(x) - int'(prev_x);
          dy = int'(y) - int'(prev_y);
          if ((dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) >= int'(move_thresh)) begin
            d = heading(dx, dy);
            // skip the first DEPTH moves, then fill the delay ring, then shift through it
            if (moves_seen >= 2 * DEPTH) begin
              h = ring_rd;
              t = ring_wr;
              sw_cur = sw_ring[h];
              sw_ring[h] = swipe_next(sw_ring[t], d);
              ring_rd = (h + 1) % DEPTH;
              ring_wr = (t + 1) % DEPTH;
            end else if (moves_seen >= DEPTH) begin
              t = ring_wr;
              prior = (t == 0) ? tsgr_pkg::SW_START : sw_ring[t-1];
              sw_ring[t] = swipe_next(prior, d);
              moves_seen++;
              if (t + 1 < DEPTH) ring_wr = t + 1;
            end else begin
              moves_seen++;
            end
            prev_x = x;
            prev_y = y;
          end
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_W'(COORD_MAX);
    return COORD_W'(v);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom_range(0, COORD_MAX));
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic send_word(logic [1:0] o, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           chk_t chk = CHK_MODEL, swipe_t typed = '0);
    swipe_t res;
    bit hit;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    pos_x <= x;
    pos_y <= y;
    do @(posedge clk); while (!in_ready);
    hit = swipe_predict(o, x, y, res);
    if (chk == CHK_MODEL && hit) swipe_expect_q.push_back(res);
    else if (chk == CHK_HIT) swipe_expect_q.push_back(typed);
    if (o != OP_UNUSED) sent_items++;
  endtask

  // stop sending and wait for every outstanding swipe
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (swipe_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_min_move(logic [15:0] v);
    drain();
    // a lift with no swipe may still be in the command queue
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    move_thresh = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(logic [1:0] o, int x, int y, chk_t chk = CHK_MODEL,
                         tsgr_pkg::dir_t d = tsgr_pkg::DIR_RIGHT, int ox = 0, int oy = 0);
    stim_row_t r;
    r.op = o;
    r.x = COORD_W'(x);
    r.y = COORD_W'(y);
    r.chk = chk;
    r.res.dir = d;
    r.res.ox = COORD_W'(ox);
    r.res.oy = COORD_W'(oy);
    directed_rows.push_back(r);
  endtask

  // one stroke of k moves of size m along a random compass direction, small jitter
  task automatic swipe_stroke(int m, bit bend);
    tsgr_pkg::dir_t d;
    int k, ux, uy, ax, ay, jit, span, cx, cy, i, jx, jy;
    d = tsgr_pkg::dir_t'($urandom_range(0, 7));
    k = $urandom_range(5, 9);
    case (d)
      tsgr_pkg::DIR_RIGHT:      begin ux = 1;  uy = 0;  end
      tsgr_pkg::DIR_UP_RIGHT:   begin ux = 1;  uy = -1; end
      tsgr_pkg::DIR_UP:         begin ux = 0;  uy = -1; end
      tsgr_pkg::DIR_UP_LEFT:    begin ux = -1; uy = -1; end
      tsgr_pkg::DIR_LEFT:       begin ux = -1; uy = 0;  end
      tsgr_pkg::DIR_DOWN_LEFT:  begin ux = -1; uy = 1;  end
      tsgr_pkg::DIR_DOWN:       begin ux = 0;  uy = 1;  end
      default:                  begin ux = 1;  uy = 1;  end
    endcase
    ax = (ux == 0) ? 0 : ((uy == 0) ? m : (m + 1) / 2);
    ay = (uy == 0) ? 0 : ((ux == 0) ? m : (m + 1) / 2);
    jit = m / 16;
    span = k * (ax > ay ? ax : ay) + jit;
    if (span > COORD_MAX) span = COORD_MAX;
    cx = (ux > 0) ? $urandom_range(0, COORD_MAX - span) :
         (ux < 0) ? $urandom_range(span, COORD_MAX) : $urandom_range(0, COORD_MAX);
    cy = (uy > 0) ? $urandom_range(0, COORD_MAX - span) :
         (uy < 0) ? $urandom_range(span, COORD_MAX) : $urandom_range(0, COORD_MAX);
    send_word(tsgr_pkg::OP_START, rand_coord(), rand_coord());
    send_word(tsgr_pkg::OP_POINT, COORD_W'(cx), COORD_W'(cy));
    for (i = 1; i <= k; i++) begin
      if (bend && i == k / 2 + 1) begin
        ux = -ux;
        uy = -uy;
      end
      // short hop that must be dropped
      if (move_thresh > 1 && $urandom_range(0, 99) < 12)
        send_word(tsgr_pkg::OP_POINT,
                  clamp_coord(cx + $urandom_range(0, (move_thresh - 1) / 2)),
                  clamp_coord(cy + $urandom_range(0, (move_thresh - 1) / 2)));
      cx += ux * ax;
      cy += uy * ay;
      jx = int'($urandom_range(0, 2 * jit)) - jit;
      jy = int'($urandom_range(0, 2 * jit)) - jit;
      send_word(tsgr_pkg::OP_POINT, clamp_coord(cx + jx), clamp_coord(cy + jy));
    end
    if ($urandom_range(0, 99) < 90)
      send_word(tsgr_pkg::OP_LIFT, rand_coord(), rand_coord());
  endtask

  task automatic noise_burst();
    int n, i;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++)
      send_word(2'($urandom_range(0, 3)), rand_coord(), rand_coord());
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[touch_swipe_gesture_recognizer] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    swipe_t want;
    if (!rst && out_valid && out_ready) begin
      if (swipe_expect_q.size() == 0) begin
        note_failure($sformatf("unexpected swipe: dir %0d origin (%0d,%0d)",
                               gesture_dir, origin_x, origin_y));
      end else begin
        want = swipe_expect_q.pop_front();
        if (gesture_dir !== want.dir || origin_x !== want.ox || origin_y !== want.oy)
          note_failure($sformatf(
            "swipe mismatch: expected dir %0d origin (%0d,%0d), got dir %0d origin (%0d,%0d)",
            want.dir, want.ox, want.oy, gesture_dir, origin_x, origin_y));
      end
    end
  end

  // result side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= quiet || ($urandom_range(0, 99) >= 15);
    end
  end

  initial begin
    int plan [8];
    int budget [8];
    int p, first_item;
    bit paused;
    stim_row_t r;

    plan = '{10, 0, 1, 250, 6553, 65535, 40000, 10};
    budget = '{110, 110, 110, 110, 110, 40, 40, 110};
    rst = 1'b1;
    in_valid = 1'b0;
    op = tsgr_pkg::OP_POINT;
    pos_x = '0;
    pos_y = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    mismatches = 0;
    sent_items = 0;
    cycles = 0;

    move_thresh = tsgr_pkg::MIN_MOVE_RESET;
    pt_valid = 1'b0;
    prev_x = '0;
    prev_y = '0;
    org_x = '0;
    org_y = '0;
    sw_cur = tsgr_pkg::SW_START;
    moves_seen = 0;
    ring_rd = 0;
    ring_wr = 0;
    foreach (sw_ring[i]) sw_ring[i] = tsgr_pkg::SW_START;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // lift right after reset, then a clean rightward swipe from the origin
    add_row(tsgr_pkg::OP_LIFT,  0,     0,     CHK_NONE);
    add_row(tsgr_pkg::OP_POINT, 0,     0,     CHK_NONE);
    add_row(tsgr_pkg::OP_POINT, 20,    0);
    add_row(tsgr_pkg::OP_POINT, 40,    0);
    add_row(tsgr_pkg::OP_POINT, 60,    0);
    add_row(tsgr_pkg::OP_POINT, 80,    0);
    add_row(tsgr_pkg::OP_POINT, 100,   0);
    add_row(tsgr_pkg::OP_LIFT,  0,     0,     CHK_HIT, tsgr_pkg::DIR_RIGHT, 0, 0);
    // leftward swipe from the far corner with large steps
    add_row(tsgr_pkg::OP_START, 32767, 32767, CHK_NONE);
    add_row(tsgr_pkg::OP_POINT, 32767, 32767, CHK_NONE);
    add_row(tsgr_pkg::OP_POINT, 24000, 32767);
    add_row(tsgr_pkg::OP_POINT, 16000, 32767);
    add_row(tsgr_pkg::OP_POINT, 8000,  32767);
    add_row(tsgr_pkg::OP_POINT, 4000,  32767);
    add_row(tsgr_pkg::OP_POINT, 0,     32767);
    add_row(tsgr_pkg::OP_LIFT,  32767, 32767, CHK_HIT, tsgr_pkg::DIR_LEFT, 32767, 32767);
    // unknown op is ignored, and a lift leaves the swipe in place
    add_row(OP_UNUSED,          32767, 32767, CHK_NONE);
    add_row(tsgr_pkg::OP_LIFT,  0,     0,     CHK_HIT, tsgr_pkg::DIR_LEFT, 32767, 32767);
    // mixed directions with a short hop ends with no gesture
    add_row(tsgr_pkg::OP_START, 0,     0,     CHK_NONE);
    add_row(tsgr_pkg::OP_POINT, 100,   100);
    add_row(tsgr_pkg::OP_POINT, 105,   100);
    add_row(tsgr_pkg::OP_POINT, 100,   50);
    add_row(tsgr_pkg::OP_POINT, 150,   0);
    add_row(tsgr_pkg::OP_POINT, 150,   100);
    add_row(tsgr_pkg::OP_POINT, 100,   150);
    add_row(tsgr_pkg::OP_POINT, 200,   150);
    add_row(tsgr_pkg::OP_POINT, 200,   250);
    add_row(tsgr_pkg::OP_LIFT,  0,     0);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_word(r.op, r.x, r.y, r.chk, r.res);
    end

    for (p = 0; p < 8; p++) begin
      if (p > 0) write_min_move(16'(plan[p]));
      quiet = (p == 3);
      paused = 1'b0;
      first_item = sent_items;
      // zero threshold: repeated identical points count as up-left moves
      if (p == 1) swipe_stroke(0, 1'b0);
      while (sent_items - first_item < budget[p]) begin
        if ($urandom_range(0, 99) < 75)
          swipe_stroke(int'(move_thresh) + $urandom_range(0, 20 + move_thresh / 4),
                       $urandom_range(0, 99) < 12);
        else
          noise_burst();
        if (!paused && sent_items - first_item >= budget[p] / 2) begin
          paused = 1'b1;
          drain();
        end
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (swipe_expect_q.size() != 0)
      note_failure($sformatf("%0d swipes never reported", swipe_expect_q.size()));
    if (mismatches == 0) $display("[touch_swipe_gesture_recognizer] OK");
    else $display("[touch_swipe_gesture_recognizer] ERROR");
    $finish;
  end

endmodule
